@@ design/msdt_pkg.sv @@
// Shared types and constants for the multi-slot deadline timer.
package msdt_pkg;

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_CANCEL  = 3'd1;
    localparam logic [2:0] OP_RESTART = 3'd2;
    localparam logic [2:0] OP_FIRE    = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;
    localparam logic [2:0] OP_FLUSH   = 3'd5;

    localparam logic [31:0] STALE_RESET = 32'd5000;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  slot;
        logic [31:0] period_ms;
        logic        periodic;
        logic [47:0] now_ms;
    } msdt_in_t;

    typedef struct packed {
        logic [3:0]  fired_slot;
        logic        fired;
        logic        status;
        logic [47:0] next_timeout;
        logic        last;
    } msdt_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_item;
        logic rd_first;
        logic do_op;
        logic scan_adv;
        logic emit_fire;
        logic emit_close;
        logic finish;
    } msdt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_op;
        logic need_fire;
        logic last_slot;
        logic out_free;
    } msdt_sts_t;

endpackage

@@ design/msdt_datapath.sv @@
// Datapath of the deadline timer: slot table, scan index, minimum tracker and result register.
module msdt_datapath
    import msdt_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 48
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  msdt_in_t  in_data,
    input  logic      cfg_we,
    input  logic [31:0] cfg_wdata,
    input  msdt_cmd_t cmd,
    output msdt_sts_t sts,
    output logic      out_valid,
    input  logic      out_ready,
    output msdt_out_t out_data
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int DW     = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int AW     = DW + 1;
    localparam logic [TIME_BITS-1:0] TMASK    = '1;
    localparam logic [SLOT_W-1:0]    LAST_IDX = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [6:0]           SLOTS_7  = 7'(NUM_SLOTS);

    // Item registers.
    logic [2:0]           op_reg;
    logic [3:0]           slot_reg;
    logic [31:0]          per_in_reg;
    logic                 periodic_in_reg;
    logic [TIME_BITS-1:0] now_reg;

    logic [31:0] stale_reg;

    logic [NUM_SLOTS-1:0] active_reg, active_next;
    logic [NUM_SLOTS-1:0] periodic_reg, periodic_next;
    logic                 status_reg, status_next;
    logic [SLOT_W-1:0]    proc_idx_reg, proc_idx_next;

    logic                 cand_valid_reg, cand_valid_next;
    logic [TIME_BITS-1:0] cand_dead_reg, cand_dead_next;
    logic                 min_valid_reg, min_valid_next;
    logic [TIME_BITS-1:0] min_reg, min_next;

    logic      out_valid_reg, out_valid_next;
    msdt_out_t out_data_reg;

    logic [31:0]          period_mem [NUM_SLOTS];
    logic [TIME_BITS-1:0] arm_mem    [NUM_SLOTS];
    logic [TIME_BITS-1:0] dead_mem   [NUM_SLOTS];
    logic [31:0]          rd_per_reg;
    logic [TIME_BITS-1:0] rd_arm_reg;
    logic [TIME_BITS-1:0] rd_dead_reg;

    logic [SLOT_W-1:0]    rd_addr;
    logic [SLOT_W-1:0]    wr_addr;
    logic                 wr_per_en;
    logic                 wr_arm_en;
    logic                 wr_dead_en;
    logic [TIME_BITS-1:0] wr_dead_data;

    logic [SLOT_W-1:0]    slot_idx;
    logic                 in_range;
    logic                 slot_act;
    logic                 scan_op;
    logic                 cur_act;
    logic                 cur_periodic;
    logic [31:0]          arm_per;
    logic [AW-1:0]        arm_sum;
    logic [TIME_BITS-1:0] arm_dead;
    logic                 due;
    logic                 fresh;
    logic                 post_act;
    logic [TIME_BITS-1:0] post_dead;
    logic [TIME_BITS-1:0] nt_val;
    logic                 last_slot;

    always_comb
    begin
        slot_idx     = SLOT_W'(slot_reg);
        in_range     = {3'b000, slot_reg} < SLOTS_7;
        slot_act     = in_range ? active_reg[slot_idx] : 1'b0;
        scan_op      = (op_reg == OP_TICK) || (op_reg == OP_FLUSH);
        cur_act      = active_reg[proc_idx_reg];
        cur_periodic = periodic_reg[proc_idx_reg];
        last_slot    = proc_idx_reg == LAST_IDX;

        // Arming saturates at the largest time instead of wrapping.
        arm_per  = (op_reg == OP_ADD) ? per_in_reg : rd_per_reg;
        arm_sum  = AW'(now_reg) + AW'(arm_per);
        arm_dead = (arm_sum > AW'(TMASK)) ? TMASK : TIME_BITS'(arm_sum);

        due   = scan_op && cur_act && (rd_dead_reg <= now_reg);
        fresh = (now_reg >= rd_arm_reg) &&
                (DW'(now_reg - rd_dead_reg) < DW'(stale_reg));

        post_act  = cur_act && !(due && !cur_periodic);
        post_dead = (due && cur_periodic) ? arm_dead : rd_dead_reg;

        if ((op_reg == OP_FLUSH) || !min_valid_reg)
        begin
            nt_val = TMASK;
        end
        else if (min_reg <= now_reg)
        begin
            nt_val = '0;
        end
        else
        begin
            nt_val = min_reg - now_reg;
        end
    end

    always_comb
    begin
        active_next   = active_reg;
        periodic_next = periodic_reg;
        status_next   = status_reg;
        wr_addr       = proc_idx_reg;
        wr_per_en     = 1'b0;
        wr_arm_en     = 1'b0;
        wr_dead_en    = 1'b0;
        wr_dead_data  = arm_dead;

        if (cmd.load)
        begin
            status_next = 1'b0;
        end

        if (cmd.do_op)
        begin
            wr_addr = slot_idx;
            unique case (op_reg)
                OP_ADD:
                begin
                    if (!in_range)
                    begin
                        status_next = 1'b1;
                    end
                    else
                    begin
                        active_next[slot_idx]   = 1'b1;
                        periodic_next[slot_idx] = periodic_in_reg;
                        wr_per_en  = 1'b1;
                        wr_arm_en  = 1'b1;
                        wr_dead_en = 1'b1;
                    end
                end
                OP_CANCEL:
                begin
                    if (!slot_act)
                    begin
                        status_next = 1'b1;
                    end
                    else
                    begin
                        active_next[slot_idx] = 1'b0;
                    end
                end
                OP_RESTART:
                begin
                    if (!slot_act)
                    begin
                        status_next = 1'b1;
                    end
                    else
                    begin
                        wr_arm_en  = 1'b1;
                        wr_dead_en = 1'b1;
                    end
                end
                OP_FIRE:
                begin
                    if (!slot_act)
                    begin
                        status_next = 1'b1;
                    end
                    else
                    begin
                        wr_dead_en   = 1'b1;
                        wr_dead_data = now_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // A due slot re-arms if periodic and clears if one-shot.
        if (cmd.scan_adv && due)
        begin
            if (cur_periodic)
            begin
                wr_arm_en  = 1'b1;
                wr_dead_en = 1'b1;
            end
            else
            begin
                active_next[proc_idx_reg] = 1'b0;
            end
        end

        if (cmd.finish && (op_reg == OP_FLUSH))
        begin
            active_next = '0;
        end
    end

    always_comb
    begin
        if (cmd.rd_item && in_range)
        begin
            rd_addr = slot_idx;
        end
        else if (cmd.rd_first)
        begin
            rd_addr = '0;
        end
        else if (cmd.scan_adv && !last_slot)
        begin
            rd_addr = proc_idx_reg + SLOT_W'(1);
        end
        else
        begin
            rd_addr = proc_idx_reg;
        end

        if (cmd.rd_first)
        begin
            proc_idx_next = '0;
        end
        else if (cmd.scan_adv && !last_slot)
        begin
            proc_idx_next = proc_idx_reg + SLOT_W'(1);
        end
        else
        begin
            proc_idx_next = proc_idx_reg;
        end

        // The post-update deadline is registered as a candidate and compared against
        // the running minimum in the cycle after the slot is processed.
        cand_valid_next = cmd.scan_adv && post_act;
        cand_dead_next  = post_dead;
        min_valid_next  = min_valid_reg;
        min_next        = min_reg;
        if (cand_valid_reg && (!min_valid_reg || (cand_dead_reg < min_reg)))
        begin
            min_valid_next = 1'b1;
            min_next       = cand_dead_reg;
        end
        if (cmd.rd_first)
        begin
            min_valid_next  = 1'b0;
            cand_valid_next = 1'b0;
        end

        if (cmd.emit_fire || cmd.emit_close)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_reg      <= STALE_RESET;
            active_reg     <= '0;
            periodic_reg   <= '0;
            status_reg     <= 1'b0;
            proc_idx_reg   <= '0;
            cand_valid_reg <= 1'b0;
            min_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                stale_reg <= cfg_wdata;
            end
            active_reg     <= active_next;
            periodic_reg   <= periodic_next;
            status_reg     <= status_next;
            proc_idx_reg   <= proc_idx_next;
            cand_valid_reg <= cand_valid_next;
            min_valid_reg  <= min_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg          <= in_data.operation;
            slot_reg        <= in_data.slot;
            per_in_reg      <= in_data.period_ms;
            periodic_in_reg <= in_data.periodic;
            now_reg         <= TIME_BITS'(in_data.now_ms);
        end
        cand_dead_reg <= cand_dead_next;
        min_reg       <= min_next;
        if (cmd.emit_fire)
        begin
            out_data_reg.fired_slot   <= 4'(proc_idx_reg);
            out_data_reg.fired        <= 1'b1;
            out_data_reg.status       <= 1'b0;
            out_data_reg.next_timeout <= '0;
            out_data_reg.last         <= 1'b0;
        end
        else if (cmd.emit_close)
        begin
            out_data_reg.fired_slot   <= '0;
            out_data_reg.fired        <= 1'b0;
            out_data_reg.status       <= status_reg;
            out_data_reg.next_timeout <= 48'(nt_val);
            out_data_reg.last         <= 1'b1;
        end
    end

    // Slot table memories: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_per_en)
        begin
            period_mem[wr_addr] <= per_in_reg;
        end
        if (wr_arm_en)
        begin
            arm_mem[wr_addr] <= now_reg;
        end
        if (wr_dead_en)
        begin
            dead_mem[wr_addr] <= wr_dead_data;
        end
        rd_per_reg  <= period_mem[rd_addr];
        rd_arm_reg  <= arm_mem[rd_addr];
        rd_dead_reg <= dead_mem[rd_addr];
    end

    assign sts.scan_op   = scan_op;
    assign sts.need_fire = due && fresh;
    assign sts.last_slot = last_slot;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(cmd.emit_fire || cmd.emit_close))
        else $error("result register overwritten while held");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && (op_reg == OP_FLUSH)) |=> (active_reg == '0))
        else $error("flush left an active slot");

    a_fire_only_due: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_fire |-> (cmd.scan_adv && due && fresh))
        else $error("fired result for a slot that is not due and fresh");

endmodule

@@ design/msdt_ctrl.sv @@
// Controller state machine that sequences each item through the slot scan.
module msdt_ctrl
    import msdt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  msdt_sts_t sts,
    output msdt_cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_OP    = 3'd2;
    localparam logic [2:0] S_RD0   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_MERGE = 3'd5;
    localparam logic [2:0] S_CLOSE = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (sts.scan_op)
                begin
                    cmd.rd_first = 1'b1;
                    state_next   = S_SCAN;
                end
                else
                begin
                    cmd.rd_item = 1'b1;
                    state_next  = S_OP;
                end
            end
            S_OP:
            begin
                cmd.do_op  = 1'b1;
                state_next = S_RD0;
            end
            S_RD0:
            begin
                cmd.rd_first = 1'b1;
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                // A fired result waits for room in the result register.
                if (!sts.need_fire || sts.out_free)
                begin
                    cmd.scan_adv  = 1'b1;
                    cmd.emit_fire = sts.need_fire;
                    if (sts.last_slot)
                    begin
                        state_next = S_MERGE;
                    end
                end
            end
            S_MERGE:
            begin
                cmd.finish = 1'b1;
                state_next = S_CLOSE;
            end
            S_CLOSE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_close = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_LOAD))
        else $error("accepted transfer did not start an item");

    a_close_ends: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_close |=> (state_reg == S_IDLE))
        else $error("closing result did not end the item");

    a_fire_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_fire |-> (state_reg == S_SCAN))
        else $error("fired result issued outside the slot scan");

endmodule

@@ design/multi_slot_deadline_timer_unit.sv @@
// Top level of the multi-slot deadline timer: controller plus datapath.
//
//  Channel   Direction  Handshake            Payload
//  in        input      in_valid/in_ready    in_data (msdt_in_t)
//  out       output     out_valid/out_ready  out_data (msdt_out_t)
//  cfg       input      cfg_we               cfg_wdata (stale window, ms)
//
// A tick or flush goes from its transfer straight into the slot scan, while add,
// cancel, restart and fire-now first perform the addressed-slot operation; the
// scan reads the slot table through its single memory read port, one slot per
// cycle unless a fired result waits for room, to find due slots and the earliest
// deadline. A fired or closing result that finds the result register still held
// by an unaccepted result waits until the register is free.
// Reset clears all slots and sets the stale window to 5000 ms; no clearing
// pass is needed since slot contents are read only for active slots.
module multi_slot_deadline_timer_unit
    import msdt_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 48
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  msdt_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output msdt_out_t   out_data,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    msdt_cmd_t cmd;
    msdt_sts_t sts;

    // The controller accepts a transfer only between items, then steps the
    // datapath through the addressed-slot operation and the full slot scan.
    msdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the slot table, the scan index, the running minimum
    // deadline and the result register that decouples the output side.
    msdt_datapath #(
        .NUM_SLOTS (NUM_SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
